FILE: src/call_stack_time_profiler_macros.svh
// Assertion macros for the call-stack time profiler.
// Used inside modules that have a clock named clock and a reset named reset.
`ifndef CALL_STACK_TIME_PROFILER_MACROS_SVH
`define CALL_STACK_TIME_PROFILER_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CSTP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define CSTP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/cstp_pkg.sv
// Shared types, sizes and codes for the call-stack time profiler.
// No dependencies; imported by cstp_table and call_stack_time_profiler.
`default_nettype none

package cstp_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int FUNC_COUNT  = 256;

   localparam int ID_W   = 8;
   localparam int TS_W   = 64;
   localparam int CNT_W  = 32;
   localparam int ID_SPAN = 2 ** ID_W;
   localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
   localparam int STK_AW = $clog2(STACK_DEPTH);
   localparam int TBL_AW = $clog2(FUNC_COUNT);

   typedef logic [LVL_W-1:0]  level_type;
   typedef logic [STK_AW-1:0] stk_addr_type;
   typedef logic [TBL_AW-1:0] tbl_addr_type;
   typedef logic [TS_W-1:0]   time_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [ID_W-1:0]   id_type;

   typedef enum logic [1:0] {
      ACT_ENTER   = 2'd0,
      ACT_EXIT    = 2'd1,
      ACT_RESTART = 2'd2,
      ACT_READ    = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REPORT,
      S_EXIT_TOP,
      S_EXIT_UPD,
      S_RESTART
   } state_type;

   typedef struct packed {
      tbl_addr_type func;
      time_type     start;
      time_type     callee;
   } frame_type;

   typedef struct packed {
      count_type count;
      time_type  self_time;
      time_type  incl_time;
   } tbl_entry_type;

   typedef struct packed {
      logic         clear;
      logic         rd_en;
      tbl_addr_type rd_addr;
      logic         wr_en;
      tbl_addr_type wr_addr;
   } tbl_ctl_type;

   // Map every possible function id onto its table slot (id modulo FUNC_COUNT).
   typedef tbl_addr_type id_map_type [ID_SPAN];

   function automatic id_map_type build_id_map();
      id_map_type m;
      for (int i = 0; i < ID_SPAN; i++) begin
         m[i] = tbl_addr_type'(i % FUNC_COUNT);
      end
      return m;
   endfunction

   localparam id_map_type ID_MAP = build_id_map();

endpackage

`default_nettype wire

FILE: src/call_stack_time_profiler.sv
// Call-stack time profiler top level: event sequencer, call-stack memory, result register.
// Depends on cstp_pkg, cstp_table and call_stack_time_profiler_macros.svh.
`default_nettype none
`include "call_stack_time_profiler_macros.svh"

// Feed one event per beat on req_* while busy is low and pulse start; the beat
// is taken at that edge. Every event yields exactly one result beat, shown on
// rsp_* for a single cycle with rsp_strobe high; there is no way to hold it, so
// the receiver must take it in that cycle. Busy falls in the cycle the result
// shows, so the next event can be taken then. Enter and read go through a table
// read, then the report; exit must first bring the top frame out of the
// single-read-port stack memory before its function's table entry can be read,
// then writes the entry back; exit on an empty stack answers straight from idle;
// restart walks every active frame, as the stack memory is rewritten one entry
// per cycle. The function table clears at once through per-entry valid bits, so
// there is no clearing pass after reset. A func_id past the table maps onto id
// modulo FUNC_COUNT. Times wrap modulo 2^64 and invocation counts saturate.
module call_stack_time_profiler import cstp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [7:0]  req_func_id,
   input  wire logic [63:0] req_timestamp,
   output logic             rsp_strobe,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_entry_id,
   output logic [31:0]      rsp_invocations,
   output logic [63:0]      rsp_self_total,
   output logic [63:0]      rsp_inclusive_total,
   output logic [63:0]      rsp_elapsed
);

   // Control state
   state_type    state_ff, state_in;
   level_type    level_ff, level_in;
   logic         rsp_strobe_ff, rsp_strobe_in;

   // Working payload
   time_type     ts_ff, ts_in;
   tbl_addr_type idx_ff, idx_in;
   status_type   status_ff, status_in;
   stk_addr_type walk_ff, walk_in;
   time_type     el_ff, el_in;
   time_type     delta_ff, delta_in;
   tbl_addr_type func_ff, func_in;

   // Result register
   status_type   rsp_status_ff, rsp_status_in;
   id_type       rsp_id_ff, rsp_id_in;
   count_type    rsp_cnt_ff, rsp_cnt_in;
   time_type     rsp_self_ff, rsp_self_in;
   time_type     rsp_incl_ff, rsp_incl_in;
   time_type     rsp_el_ff, rsp_el_in;

   // Stack memory
   frame_type    stk_mem [STACK_DEPTH];
   frame_type    stk_rd_ff;
   logic         stk_re;
   stk_addr_type stk_raddr;
   logic         stk_we;
   logic         stk_we_func;
   stk_addr_type stk_waddr;
   frame_type    stk_wdata;

   // Table port
   tbl_ctl_type   tbl_ctl;
   tbl_entry_type tbl_wdata;
   tbl_entry_type tbl_rdata;
   tbl_entry_type tbl_upd;

   tbl_addr_type req_idx;
   level_type    lvl_m1;
   level_type    lvl_m2;
   logic         accept;

   assign req_idx = ID_MAP[req_func_id];
   assign lvl_m1  = level_ff - LVL_W'(1);
   assign lvl_m2  = level_ff - LVL_W'(2);
   assign accept  = start && (state_ff == S_IDLE);

   cstp_table u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .wr_data (tbl_wdata),
      .rd_data (tbl_rdata)
   );

   // Updated table entry for an exit: count saturates, times wrap.
   always_comb begin
      tbl_upd.count     = (tbl_rdata.count == '1) ? tbl_rdata.count
                                                  : tbl_rdata.count + CNT_W'(1);
      tbl_upd.self_time = tbl_rdata.self_time + delta_ff;
      tbl_upd.incl_time = tbl_rdata.incl_time + el_ff;
   end

   always_comb begin
      state_in      = state_ff;
      level_in      = level_ff;
      ts_in         = ts_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      walk_in       = walk_ff;
      el_in         = el_ff;
      delta_in      = delta_ff;
      func_in       = func_ff;

      rsp_strobe_in = 1'b0;
      rsp_status_in = ST_OK;
      rsp_id_in     = '0;
      rsp_cnt_in    = '0;
      rsp_self_in   = '0;
      rsp_incl_in   = '0;
      rsp_el_in     = '0;

      stk_re        = 1'b0;
      stk_raddr     = '0;
      stk_we        = 1'b0;
      stk_we_func   = 1'b0;
      stk_waddr     = '0;
      stk_wdata     = '0;

      tbl_ctl       = '0;
      tbl_wdata     = tbl_upd;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               ts_in  = req_timestamp;
               idx_in = req_idx;
               case (action_type'(req_action))
                  ACT_ENTER: begin
                     // Read the entry to report; push a frame unless full.
                     tbl_ctl.rd_en   = 1'b1;
                     tbl_ctl.rd_addr = req_idx;
                     if (level_ff == LVL_W'(STACK_DEPTH)) begin
                        status_in = ST_OVERFLOW;
                     end else begin
                        status_in        = ST_OK;
                        stk_we           = 1'b1;
                        stk_we_func      = 1'b1;
                        stk_waddr        = level_ff[STK_AW-1:0];
                        stk_wdata.func   = req_idx;
                        stk_wdata.start  = req_timestamp;
                        stk_wdata.callee = '0;
                        level_in         = level_ff + LVL_W'(1);
                     end
                     state_in = S_REPORT;
                  end
                  ACT_EXIT: begin
                     if (level_ff == '0) begin
                        // Nothing to pop: answer at once with ST_EMPTY and all other fields zero.
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        stk_re    = 1'b1;
                        stk_raddr = lvl_m1[STK_AW-1:0];
                        state_in  = S_EXIT_TOP;
                     end
                  end
                  ACT_RESTART: begin
                     tbl_ctl.clear = 1'b1;
                     if (level_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        walk_in  = '0;
                        state_in = S_RESTART;
                     end
                  end
                  ACT_READ: begin
                     tbl_ctl.rd_en   = 1'b1;
                     tbl_ctl.rd_addr = req_idx;
                     status_in       = ST_OK;
                     state_in        = S_REPORT;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_REPORT: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = status_ff;
            rsp_id_in     = ID_W'(idx_ff);
            rsp_cnt_in    = tbl_rdata.count;
            rsp_self_in   = tbl_rdata.self_time;
            rsp_incl_in   = tbl_rdata.incl_time;
            state_in      = S_IDLE;
         end

         S_EXIT_TOP: begin
            // Top frame is out: take elapsed and self delta, fetch the entry
            // and the caller frame.
            el_in           = ts_ff - stk_rd_ff.start;
            delta_in        = ts_ff - stk_rd_ff.start - stk_rd_ff.callee;
            func_in         = stk_rd_ff.func;
            tbl_ctl.rd_en   = 1'b1;
            tbl_ctl.rd_addr = stk_rd_ff.func;
            if (level_ff > LVL_W'(1)) begin
               stk_re    = 1'b1;
               stk_raddr = lvl_m2[STK_AW-1:0];
            end
            state_in = S_EXIT_UPD;
         end

         S_EXIT_UPD: begin
            tbl_ctl.wr_en   = 1'b1;
            tbl_ctl.wr_addr = func_ff;
            if (level_ff > LVL_W'(1)) begin
               // Charge the call to the caller's callee total.
               stk_we           = 1'b1;
               stk_waddr        = lvl_m2[STK_AW-1:0];
               stk_wdata.func   = stk_rd_ff.func;
               stk_wdata.start  = stk_rd_ff.start;
               stk_wdata.callee = stk_rd_ff.callee + el_ff;
            end
            level_in      = lvl_m1;
            rsp_strobe_in = 1'b1;
            rsp_status_in = ST_OK;
            rsp_id_in     = ID_W'(func_ff);
            rsp_cnt_in    = tbl_upd.count;
            rsp_self_in   = tbl_upd.self_time;
            rsp_incl_in   = tbl_upd.incl_time;
            rsp_el_in     = el_ff;
            state_in      = S_IDLE;
         end

         S_RESTART: begin
            // Restart one active frame per cycle, keeping its function.
            stk_we           = 1'b1;
            stk_waddr        = walk_ff;
            stk_wdata.start  = ts_ff;
            stk_wdata.callee = '0;
            if (LVL_W'(walk_ff) == lvl_m1) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               walk_in = walk_ff + STK_AW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         level_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         level_ff      <= level_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ts_ff         <= ts_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      walk_ff       <= walk_in;
      el_ff         <= el_in;
      delta_ff      <= delta_in;
      func_ff       <= func_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_cnt_ff    <= rsp_cnt_in;
      rsp_self_ff   <= rsp_self_in;
      rsp_incl_ff   <= rsp_incl_in;
      rsp_el_ff     <= rsp_el_in;
   end

   // Stack memory: one write and one registered read per cycle. The function
   // field is written only on push so a restart keeps it.
   always_ff @(posedge clock) begin
      if (stk_we) begin
         if (stk_we_func) begin
            stk_mem[stk_waddr].func <= stk_wdata.func;
         end
         stk_mem[stk_waddr].start  <= stk_wdata.start;
         stk_mem[stk_waddr].callee <= stk_wdata.callee;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_entry_id        = rsp_id_ff;
   assign rsp_invocations     = rsp_cnt_ff;
   assign rsp_self_total      = rsp_self_ff;
   assign rsp_inclusive_total = rsp_incl_ff;
   assign rsp_elapsed         = rsp_el_ff;

   `CSTP_ASSERT_NOW(a_rsp_when_idle, rsp_strobe, !busy, "result beat while sequencer busy")
   `CSTP_ASSERT_NEXT(a_empty_exit, accept && (req_action == ACT_EXIT) && (level_ff == '0), rsp_strobe && (rsp_status == ST_EMPTY) && (level_ff == '0), "exit on empty stack not flagged")
   `CSTP_ASSERT_NEXT(a_exit_pops, state_ff == S_EXIT_UPD, (level_ff == $past(lvl_m1)) && rsp_strobe, "exit did not pop one frame")
   `CSTP_ASSERT_NOW(a_walk_in_stack, state_ff == S_RESTART, (LVL_W'(walk_ff) < level_ff) && (level_ff <= LVL_W'(STACK_DEPTH)), "restart walk outside active frames")

endmodule

`default_nettype wire

FILE: src/cstp_table.sv
// Per-function totals table: one-port-read, one-port-write memory with valid bits.
// Depends on cstp_pkg; instantiated by call_stack_time_profiler.
`default_nettype none

module cstp_table import cstp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire tbl_ctl_type   ctl,
   input  wire tbl_entry_type wr_data,
   output tbl_entry_type      rd_data
);

   tbl_entry_type           tbl_mem [FUNC_COUNT];
   logic [FUNC_COUNT-1:0]   valid_ff;
   logic [FUNC_COUNT-1:0]   valid_in;
   tbl_entry_type           rd_ff;
   logic                    rd_vld_ff;

   // Drop every valid bit on clear; mark an entry on write.
   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         tbl_mem[ctl.wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_ff     <= tbl_mem[ctl.rd_addr];
         rd_vld_ff <= valid_ff[ctl.rd_addr];
      end
   end

   // An entry not written since reset or restart reads as zero.
   assign rd_data = rd_vld_ff ? rd_ff : '0;

endmodule

`default_nettype wire
